// ===== design/bdlp_pkg.sv =====
// Shared types, constants and register map of the button debouncer.
package bdlp_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int DELAY_W       = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_DELAY = 3'd0,
    REG_ACTIVE_LEVEL   = 3'd1,
    REG_LONG_ENABLE    = 3'd2,
    REG_LONG_DELAY     = 3'd3,
    REG_REPEAT_DELAY   = 3'd4
  } cfg_reg_t;

  localparam logic [DELAY_W-1:0] DEBOUNCE_RST = 16'd50;

  typedef struct packed {
    logic [DELAY_W-1:0] debounce_delay_ms;
    logic               active_level;
    logic               long_press_enable;
    logic [DELAY_W-1:0] long_press_delay_ms;
    logic [DELAY_W-1:0] repeat_delay_ms;
  } cfg_t;

endpackage

// ===== design/bdlp_if.sv =====
// Valid/ready channel interfaces for pin samples and press results.
interface bdlp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       pin_level;
  logic [bdlp_pkg::NOW_W-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       pressed;

  modport source (output valid, output event_res, output pressed, input ready);
  modport sink   (input valid, input event_res, input pressed, output ready);
endinterface

// ===== design/bdlp_cfg.sv =====
// Configuration register file of the button debouncer.
module bdlp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0] data,
  output bdlp_pkg::cfg_t                  cfg
);
  import bdlp_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (cfg_reg_t'(index))
        REG_DEBOUNCE_DELAY: cfg_nxt.debounce_delay_ms   = data;
        REG_ACTIVE_LEVEL:   cfg_nxt.active_level        = data[0];
        REG_LONG_ENABLE:    cfg_nxt.long_press_enable   = data[0];
        REG_LONG_DELAY:     cfg_nxt.long_press_delay_ms = data;
        REG_REPEAT_DELAY:   cfg_nxt.repeat_delay_ms     = data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_delay_ms   <= DEBOUNCE_RST;
      cfg_r.active_level        <= 1'b0;
      cfg_r.long_press_enable   <= 1'b0;
      cfg_r.long_press_delay_ms <= '0;
      cfg_r.repeat_delay_ms     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== design/bdlp_core.sv =====
// Debounce and long-press state with its single-pass update logic.
module bdlp_core #(
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdlp_pkg::cfg_t             cfg,
  input  logic                       step,
  input  logic                       level,
  input  logic [bdlp_pkg::NOW_W-1:0] now_ms,
  output bdlp_pkg::event_t           event_res,
  output logic                       pressed
);
  import bdlp_pkg::*;

  logic                 last_raw_r, last_raw_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] change_r, change_nxt;
  logic [TIME_BITS-1:0] hold_r, hold_nxt;
  logic                 long_r, long_nxt;

  logic [TIME_BITS-1:0] now_t, el_db, el_hold, hold_a;
  logic                 deb_ok, release_ev, press_ev, long_a, held;
  logic                 rep_on;
  event_t               ev;

  always_comb begin
    now_t      = TIME_BITS'(now_ms);
    change_nxt = (level != last_raw_r) ? now_t : change_r;
    el_db      = now_t - change_nxt;
    deb_ok     = el_db > TIME_BITS'(cfg.debounce_delay_ms);
    release_ev = deb_ok && (stable_r == cfg.active_level) && (level != cfg.active_level);
    press_ev   = deb_ok && (stable_r != cfg.active_level) && (level == cfg.active_level);
    stable_nxt = deb_ok ? level : stable_r;
    rep_on     = cfg.repeat_delay_ms != '0;

    ev     = EV_NONE;
    hold_a = hold_r;
    long_a = long_r;
    if (release_ev) begin
      if (!(cfg.long_press_enable && long_r)) ev = EV_SHORT;
      else if (!rep_on)                       ev = EV_LONG;
      hold_a = '0;
      long_a = 1'b0;
    end
    if (press_ev) hold_a = now_t;

    held     = stable_nxt == cfg.active_level;
    el_hold  = now_t - hold_a;
    hold_nxt = hold_a;
    long_nxt = long_a;
    if (held && cfg.long_press_enable && (cfg.long_press_delay_ms != '0) && !long_a &&
        (el_hold > TIME_BITS'(cfg.long_press_delay_ms))) begin
      long_nxt = 1'b1;
      if (rep_on) begin
        ev       = EV_LONG;
        hold_nxt = now_t;
      end
    end else if (held && cfg.long_press_enable && long_a && rep_on &&
                 (el_hold > TIME_BITS'(cfg.repeat_delay_ms))) begin
      ev       = EV_LONG;
      hold_nxt = now_t;
    end
    last_raw_nxt = level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      stable_r   <= 1'b1;
      change_r   <= '0;
      hold_r     <= '0;
      long_r     <= 1'b0;
    end else if (step) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      change_r   <= change_nxt;
      hold_r     <= hold_nxt;
      long_r     <= long_nxt;
    end
  end

  assign event_res = ev;
  assign pressed   = held;
endmodule

// ===== design/button_debounce_long_press.sv =====
// Button debouncer with long-press recognition and auto-repeat, top level.
// A sample goes to the input register, through one pass of logic, then to the
// result register once the output is free. Throughput: one sample per clock
// unless the output stalls; the result register lets a new sample in while a
// finished result waits. Synchronous active-low reset clears the pipeline
// valids and loads the register reset values; no clearing pass.
module button_debounce_long_press #(
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bdlp_in_if.sink                         in_ch,
  bdlp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bdlp_pkg::*;

  cfg_t             cfg;
  logic             in_valid_r;
  logic             in_level_r;
  logic [NOW_W-1:0] in_now_r;
  logic             out_valid_r;
  event_t           out_event_r;
  logic             out_pressed_r;
  logic             adv, step, in_take;
  event_t           core_event;
  logic             core_pressed;

  bdlp_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  assign adv     = !out_valid_r || out_ch.ready;
  assign step    = in_valid_r && adv;
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_valid_r || adv;

  bdlp_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .level     (in_level_r),
    .now_ms    (in_now_r),
    .event_res (core_event),
    .pressed   (core_pressed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (adv)         out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level_r <= in_ch.pin_level;
      in_now_r   <= in_ch.now_ms;
    end
    if (step) begin
      out_event_r   <= core_event;
      out_pressed_r <= core_pressed;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_event_r;
  assign out_ch.pressed   = out_pressed_r;
endmodule

// ===== design/bdlp_checker.sv =====
// Port-level assertions for the button debouncer, bound to the top level.
module bdlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic       out_pressed
);
  import bdlp_pkg::*;

  // result register comes out of reset empty
  a_out_empty_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a short press is only reported on a release
  a_short_is_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == EV_SHORT)) |-> !out_pressed)
    else $error("short press reported while still pressed");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_event_res) && $stable(out_pressed)))
    else $error("result changed while stalled");
endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_event_res (out_ch.event_res),
  .out_pressed   (out_ch.pressed)
);
